// File: design/dpfc_pkg.sv
// Package for the display packet framer: item types, packet codes and the CRC-8 step.
// No dependencies; used by every module of the block and by the checker.
`timescale 1ns / 1ps
`default_nettype none

package dpfc_pkg;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] CMD_DIRECT   = 8'h01;
  localparam logic [7:0] CMD_SETADDR  = 8'h05;
  localparam logic [7:0] CMD_PUT      = 8'h07;
  localparam logic [7:0] CMD_COMMIT   = 8'h08;
  localparam logic [7:0] CTRL_DISPLAY = 8'h04;
  localparam logic [7:0] CTRL_BASE    = 8'h08;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic       mode;
    logic [7:0] character;
    logic       disp_en;
    logic       curs_en;
    logic       blnk_en;
  } in_item_t;

  typedef struct packed {
    logic [7:0] command_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [7:0] check_byte;
    logic       last_of_run;
  } out_item_t;

  // one packet before its check byte is known
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] d0;
    logic [7:0] d1;
  } pkt_t;

  // all packets caused by one item; cnt is 0..3, only jobs with cnt 1..3 are queued
  typedef struct packed {
    logic [1:0]       cnt;
    pkt_t [2:0]       pkts;
  } job_t;

  // reflected CRC-8, one byte
  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] a;
    a = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: design/display_packet_framer_crc8_unit.sv
// Top level of the display packet framer: front end, job queue, back end.
// Depends on dpfc_pkg, dpfc_front, dpfc_queue, dpfc_back.
//
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------
//   input   | in_valid, in_ready, in_data    | dpfc_pkg::in_item_t
//   result  | out_valid, out_ready, out_data | dpfc_pkg::out_item_t
//
// The front end takes one item per cycle while the queue has room; an item
// that only holds a character is taken but sends nothing.
// The back end sends one packet per cycle while the result is not stalled;
// an item gives 1 to 3 packets there (its packet count).
// First packet of an item goes through the queue, CRC stages s1, s2 and the output register.
// Synchronous active-low reset clears the string state, queue and pipeline.
// A stalled result holds the pipeline; the queue absorbs QUEUE_DEPTH jobs.
`timescale 1ns / 1ps
`default_nettype none

module display_packet_framer_crc8_unit #(
  parameter int QUEUE_DEPTH = dpfc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dpfc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dpfc_pkg::out_item_t      out_data
);

  logic           fj_valid, fj_ready, hd_valid, hd_pop;
  dpfc_pkg::job_t fj, hd_job;

  dpfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  dpfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .head_valid (hd_valid),
    .pop        (hd_pop),
    .head_job   (hd_job)
  );

  dpfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (hd_valid),
    .job       (hd_job),
    .job_pop   (hd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: design/dpfc_front.sv
// Front end: accepts items, keeps the string state and turns each item into a job.
// Depends on dpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpfc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dpfc_pkg::in_item_t in_data,
  output logic                 job_valid,
  input  wire logic            job_ready,
  output dpfc_pkg::job_t       job
);

  logic [7:0] held_r, held_nxt;
  logic       pending_r, pending_nxt;
  logic       open_r, open_nxt;
  logic       accept;

  dpfc_pkg::pkt_t p_set, p_commit, p_direct, p_put_pair, p_put_tail, p_put_empty, p_none;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p_set       = '{cmd: dpfc_pkg::CMD_SETADDR, d0: 8'h00, d1: 8'h00};
    p_commit    = '{cmd: dpfc_pkg::CMD_COMMIT, d0: 8'h00, d1: 8'h00};
    p_direct    = '{cmd: dpfc_pkg::CMD_DIRECT, d0: dpfc_pkg::CTRL_DISPLAY,
                    d1: dpfc_pkg::CTRL_BASE | {5'd0, in_data.disp_en,
                                               in_data.curs_en, in_data.blnk_en}};
    p_put_pair  = '{cmd: dpfc_pkg::CMD_PUT, d0: held_r, d1: in_data.character};
    p_put_tail  = '{cmd: dpfc_pkg::CMD_PUT, d0: held_r, d1: 8'h00};
    p_put_empty = '{cmd: dpfc_pkg::CMD_PUT, d0: 8'h00, d1: 8'h00};
    p_none      = '0;

    job         = '0;
    held_nxt    = held_r;
    pending_nxt = pending_r;
    open_nxt    = open_r;

    if (!in_data.mode) begin
      // control request leaves the string state alone
      job.cnt  = 2'd1;
      job.pkts = {p_none, p_none, p_direct};
    end else if (in_data.character != 8'h00) begin
      open_nxt = 1'b1;
      if (pending_r) begin
        held_nxt    = 8'h00;
        pending_nxt = 1'b0;
      end else begin
        held_nxt    = in_data.character;
        pending_nxt = 1'b1;
      end
      case ({open_r, pending_r})
        2'b00: begin
          job.cnt  = 2'd1;
          job.pkts = {p_none, p_none, p_set};
        end
        2'b01: begin
          job.cnt  = 2'd2;
          job.pkts = {p_none, p_put_pair, p_set};
        end
        2'b11: begin
          job.cnt  = 2'd1;
          job.pkts = {p_none, p_none, p_put_pair};
        end
        default: begin
          job.cnt  = 2'd0;  // character held, nothing to send
          job.pkts = {p_none, p_none, p_none};
        end
      endcase
    end else begin
      held_nxt    = 8'h00;
      pending_nxt = 1'b0;
      open_nxt    = 1'b0;
      if (!open_r) begin
        job.cnt  = 2'd3;
        job.pkts = {p_commit, p_put_empty, p_set};
      end else if (pending_r) begin
        job.cnt  = 2'd2;
        job.pkts = {p_none, p_commit, p_put_tail};
      end else begin
        job.cnt  = 2'd1;
        job.pkts = {p_none, p_none, p_commit};
      end
    end
  end

  assign job_valid = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 8'h00;
      pending_r <= 1'b0;
      open_r    <= 1'b0;
    end else if (accept) begin
      held_r    <= held_nxt;
      pending_r <= pending_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/dpfc_queue.sv
// Short job queue between front and back end, show-ahead head.
// Depends on dpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpfc_queue #(
  parameter int DEPTH = dpfc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire dpfc_pkg::job_t push_job,
  output logic                head_valid,
  input  wire logic           pop,
  output dpfc_pkg::job_t      head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dpfc_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slots[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: design/dpfc_back.sv
// Back end: walks the packets of the head job and runs them through a
// three-stage CRC pipeline, one byte per stage; last stage is the output register.
// Depends on dpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpfc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire dpfc_pkg::job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dpfc_pkg::out_item_t out_data
);

  logic [1:0]          idx_r, idx_nxt;
  logic                s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, o_v_r, o_v_nxt;
  dpfc_pkg::pkt_t      s1_pkt_r, s2_pkt_r, cur_pkt;
  logic                s1_last_r, s2_last_r, cur_last;
  logic [7:0]          s1_crc_r, s2_crc_r;
  dpfc_pkg::out_item_t o_r;
  logic                s1_ready, s2_ready, o_ready, issue;

  assign o_ready  = !o_v_r || out_ready;
  assign s2_ready = !s2_v_r || o_ready;
  assign s1_ready = !s1_v_r || s2_ready;

  assign cur_pkt  = job.pkts[idx_r];
  assign cur_last = (idx_r == job.cnt - 2'd1);
  assign issue    = job_valid && s1_ready;
  assign job_pop  = issue && cur_last;

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = cur_last ? 2'd0 : idx_r + 2'd1;
    end
    s1_v_nxt = s1_ready ? issue : s1_v_r;
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
    o_v_nxt  = o_ready ? s2_v_r : o_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_pkt_r  <= cur_pkt;
      s1_last_r <= cur_last;
      s1_crc_r  <= dpfc_pkg::crc_byte(8'h00, cur_pkt.cmd);
    end
    if (s2_ready) begin
      s2_pkt_r  <= s1_pkt_r;
      s2_last_r <= s1_last_r;
      s2_crc_r  <= dpfc_pkg::crc_byte(s1_crc_r, s1_pkt_r.d0);
    end
    if (o_ready) begin
      o_r.command_byte <= s2_pkt_r.cmd;
      o_r.first_data   <= s2_pkt_r.d0;
      o_r.second_data  <= s2_pkt_r.d1;
      o_r.check_byte   <= dpfc_pkg::crc_byte(s2_crc_r, s2_pkt_r.d1);
      o_r.last_of_run  <= s2_last_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

`default_nettype wire

// File: design/dpfc_checker.sv
// Port-level checker for the display packet framer, bound to the top level.
// Depends on dpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpfc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dpfc_pkg::out_item_t out_data
);

  logic [7:0] crc_exp;

  assign crc_exp = dpfc_pkg::crc_byte(dpfc_pkg::crc_byte(dpfc_pkg::crc_byte(8'h00,
                     out_data.command_byte), out_data.first_data), out_data.second_data);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.check_byte == crc_exp)
    else $error("check byte does not match packet");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command_byte == dpfc_pkg::CMD_DIRECT ||
                  out_data.command_byte == dpfc_pkg::CMD_COMMIT) |-> out_data.last_of_run)
    else $error("direct or commit packet not last of its item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind display_packet_framer_crc8_unit dpfc_checker u_dpfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: dv/display_packet_framer_crc8_unit_check.sv
// Checker for the display packet framer: watches both channels, predicts the packets
// of every accepted item and compares them in order. Depends on dpfc_pkg.
`timescale 1ns / 1ps

module display_packet_framer_crc8_unit_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dpfc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dpfc_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  packets_owed,
  output int                  items_taken,
  output int                  packets_matched
);

  // framer state as seen by the predictor
  logic [7:0] pair_char;
  logic       pair_waiting;
  logic       text_open;

  dpfc_pkg::out_item_t owed_packets[$];

  initial begin
    fail_count      = 0;
    packets_owed    = 0;
    items_taken     = 0;
    packets_matched = 0;
    pair_char       = 8'h00;
    pair_waiting    = 1'b0;
    text_open       = 1'b0;
  end

  // reflected CRC-8, fed bit by bit, first byte lsb first
  function automatic logic [7:0] crc8_of(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2);
    logic [7:0]  r;
    logic [23:0] stream;
    logic        fb;
    r = 8'h00;
    stream = {b2, b1, b0};
    for (int i = 0; i < 24; i++) begin
      fb = r[0] ^ stream[i];
      r = r >> 1;
      if (fb) r = r ^ 8'h8C;
    end
    return r;
  endfunction

  task automatic predict_packets(input dpfc_pkg::in_item_t it);
    dpfc_pkg::pkt_t run[$];
    dpfc_pkg::out_item_t p;
    if (it.mode == 1'b0) begin
      run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_DIRECT, dpfc_pkg::CTRL_DISPLAY,
                                     dpfc_pkg::CTRL_BASE |
                                     {5'b0, it.disp_en, it.curs_en, it.blnk_en}});
    end else if (it.character != 8'h00) begin
      if (!text_open) begin
        run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_SETADDR, 8'h00, 8'h00});
        text_open = 1'b1;
      end
      if (pair_waiting) begin
        run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_PUT, pair_char, it.character});
        pair_waiting = 1'b0;
        pair_char = 8'h00;
      end else begin
        pair_char = it.character;
        pair_waiting = 1'b1;
      end
    end else begin
      // terminator; an empty string still gets address, blank pair and commit
      if (!text_open) begin
        run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_SETADDR, 8'h00, 8'h00});
        run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_PUT, 8'h00, 8'h00});
      end else if (pair_waiting) begin
        run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_PUT, pair_char, 8'h00});
      end
      run.push_back(dpfc_pkg::pkt_t'{dpfc_pkg::CMD_COMMIT, 8'h00, 8'h00});
      pair_char = 8'h00;
      pair_waiting = 1'b0;
      text_open = 1'b0;
    end
    for (int i = 0; i < run.size(); i++) begin
      p.command_byte = run[i].cmd;
      p.first_data   = run[i].d0;
      p.second_data  = run[i].d1;
      p.check_byte   = crc8_of(run[i].cmd, run[i].d0, run[i].d1);
      p.last_of_run  = (i == run.size() - 1);
      owed_packets.push_back(p);
    end
  endtask

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_packet(input dpfc_pkg::out_item_t got);
    dpfc_pkg::out_item_t want;
    if (owed_packets.size() == 0) begin
      report($sformatf("unexpected packet cmd=%02h d0=%02h d1=%02h crc=%02h last=%0b",
                       got.command_byte, got.first_data, got.second_data,
                       got.check_byte, got.last_of_run));
      return;
    end
    want = owed_packets.pop_front();
    if (got.command_byte !== want.command_byte || got.first_data !== want.first_data ||
        got.second_data !== want.second_data || got.check_byte !== want.check_byte ||
        got.last_of_run !== want.last_of_run) begin
      report({$sformatf("expected %02h %02h %02h crc=%02h last=%0b",
                        want.command_byte, want.first_data, want.second_data,
                        want.check_byte, want.last_of_run),
              $sformatf(", got %02h %02h %02h crc=%02h last=%0b",
                        got.command_byte, got.first_data, got.second_data,
                        got.check_byte, got.last_of_run)});
    end else begin
      packets_matched++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pair_char    = 8'h00;
      pair_waiting = 1'b0;
      text_open    = 1'b0;
      owed_packets.delete();
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        predict_packets(in_data);
      end
      if (out_valid && out_ready) check_packet(out_data);
    end
    packets_owed = owed_packets.size();
  end

endmodule

// File: dv/display_packet_framer_crc8_unit_test.sv
// Testbench top for the display packet framer: clock, reset, item stimulus and verdict.
// Depends on dpfc_pkg, the framer RTL and display_packet_framer_crc8_unit_check.
`timescale 1ns / 1ps

module display_packet_framer_crc8_unit_test;

  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_ITEMS = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dpfc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dpfc_pkg::out_item_t out_data;

  int fail_count, packets_owed, items_taken, packets_matched;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_done = 0;
  int items_sent = 0;
  int strings_sent = 0;

  always #1 clk = ~clk;

  display_packet_framer_crc8_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  display_packet_framer_crc8_unit_check checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .packets_owed   (packets_owed),
    .items_taken    (items_taken),
    .packets_matched(packets_matched)
  );

  // receiver: random stalls, or a long hold when the stimulus asks for one
  initial begin
    forever begin
      @(posedge clk);
      if (holds_requested != holds_done) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d packets outstanding", packets_owed);
    $display("TB_ERROR");
    $finish;
  end

  function automatic dpfc_pkg::in_item_t control_item(input logic d, input logic c,
                                                      input logic b, input logic [7:0] ch);
    dpfc_pkg::in_item_t it;
    it.mode = 1'b0;
    it.character = ch;
    it.disp_en = d;
    it.curs_en = c;
    it.blnk_en = b;
    return it;
  endfunction

  function automatic dpfc_pkg::in_item_t print_item(input logic [7:0] ch);
    dpfc_pkg::in_item_t it;
    it.mode = 1'b1;
    it.character = ch;
    it.disp_en = 1'($urandom_range(1));
    it.curs_en = 1'($urandom_range(1));
    it.blnk_en = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic dpfc_pkg::in_item_t random_control();
    return control_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 8'($urandom_range(255)));
  endfunction

  // offer one item, holding valid until it is taken
  task automatic offer(input dpfc_pkg::in_item_t it);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // a string of len nonzero characters and its terminator, maybe with control items inside
  task automatic send_string(input int len, input bit mix_control);
    for (int i = 0; i < len; i++) begin
      if (mix_control && $urandom_range(9) == 0) offer(random_control());
      offer(print_item(8'($urandom_range(1, 255))));
    end
    offer(print_item(8'h00));
    strings_sent++;
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int pick;
    dpfc_pkg::in_item_t it;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_string(($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6),
                    1'b1);
      end else if (pick < 85) begin
        offer(random_control());
      end else begin
        // noise: unstructured items, terminators included
        it = ($urandom_range(1) == 1) ? print_item(8'($urandom_range(255)))
                                      : random_control();
        if ($urandom_range(3) == 0) it.character = 8'h00;
        offer(it);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every control combination, character field set to differing values
    for (int k = 0; k < 8; k++) offer(control_item(k[2], k[1], k[0], 8'(k * 37)));
    offer(print_item(8'h00));                 // empty string
    offer(print_item(8'h41));                 // one char, odd tail
    offer(print_item(8'h00));
    offer(print_item(8'h01));                 // exact pair
    offer(print_item(8'hFF));
    offer(print_item(8'h00));
    offer(print_item(8'h80));                 // control while a char is held
    offer(control_item(1'b1, 1'b1, 1'b1, 8'hFF));
    offer(print_item(8'h7F));
    offer(print_item(8'h55));
    offer(print_item(8'h00));
    offer(print_item(8'hAA));                 // control after a full pair, before the terminator
    offer(print_item(8'h01));
    offer(control_item(1'b0, 1'b0, 1'b0, 8'h00));
    offer(print_item(8'h00));

    // no idling, then a long output hold while strings keep coming
    sender_idle_pct = 0;
    stall_pct = 0;
    random_traffic(RANDOM_ITEMS / 5);
    holds_requested++;
    for (int s = 0; s < 8; s++) send_string($urandom_range(2, 6), 1'b0);
    random_traffic(RANDOM_ITEMS / 5);

    sender_idle_pct = 79;
    stall_pct = 0;
    random_traffic(RANDOM_ITEMS / 5);

    sender_idle_pct = 0;
    stall_pct = 79;
    random_traffic(RANDOM_ITEMS / 5);

    sender_idle_pct = 17;
    stall_pct = 17;
    random_traffic(RANDOM_ITEMS / 5);

    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && packets_owed != 0; w++) @(posedge clk);
    repeat (12) @(posedge clk);

    if (packets_owed != 0) $display("%0d expected packets never arrived", packets_owed);
    $display("covered %0d items (%0d strings), %0d packets matched, %0d mismatches",
             items_taken, strings_sent, packets_matched, fail_count);
    $display("phases: free running, long output hold, sender idle, receiver stall, mixed");
    if (fail_count == 0 && packets_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
